FILE: rtl/core/irc_pkg.sv
// ---------------------------------------------------------------------------
// irc_pkg: shared types and constants for the reflector cluster detector
// Payload structs, register indexes, controller/datapath command and status.
// ---------------------------------------------------------------------------
package irc_pkg;

    localparam int BEAM_COUNT  = 4096;
    localparam int CNT_W       = $clog2(BEAM_COUNT) + 1;   // counter holds BEAM_COUNT
    localparam int IDX_W       = $clog2(BEAM_COUNT);
    localparam int INT_W       = 16;
    localparam int RNG_W       = 16;
    localparam int WS_W        = 28;
    localparam int IWS_W       = 40;
    localparam int RWS_W       = 44;
    localparam int CFG_W       = 23;
    localparam int CFG_IDX_W   = 3;
    localparam int FRAC_W      = 8;
    localparam int DVD_W       = IWS_W + FRAC_W;           // 48
    localparam int Q_W         = 20;
    localparam int DIV_CNT_W   = $clog2(DVD_W + 1);
    localparam int STEP_W      = 18;
    localparam int WIDTH_W     = IDX_W + STEP_W;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_POINTS = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_SPAN   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_WIDTH  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_WIDTH  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_ANGLE_STEP = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_RANGE_LO   = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_RANGE_HI   = 3'd7;

    typedef struct packed {
        logic [INT_W-1:0] beam_intensity;
        logic [RNG_W-1:0] beam_range_mm;
        logic             range_finite;
        logic             last_beam;
    } beam_t;

    typedef struct packed {
        logic [Q_W-1:0]   center_index_q8;
        logic [IDX_W-1:0] peak_index;
        logic [IDX_W-1:0] start_index;
        logic [IDX_W-1:0] end_index;
        logic [INT_W-1:0] peak_intensity;
        logic [RNG_W-1:0] center_range_mm;
    } result_t;

    typedef struct packed {
        logic load;
        logic eval;
        logic accum;
        logic width;
        logic div_start;
        logic div_sel;      // 0: center index, 1: center range
        logic cap_center;
        logic cap_range;
        logic emit;
    } cmd_t;

    typedef struct packed {
        logic close;
        logic accept;
        logic div_done;
        logic out_free;
    } status_t;

endpackage

FILE: rtl/core/intensity_reflector_cluster_detect.sv
// ---------------------------------------------------------------------------
// intensity_reflector_cluster_detect: lidar reflector cluster detector
// Groups bright beams into clusters and reports weighted centers of good ones.
// ---------------------------------------------------------------------------
// A beam is taken, evaluated and accumulated in turn. A beam that closes a
// cluster adds the width and acceptance checks. An accepted cluster then
// runs two 48-step divisions on the shared restoring divider (index and
// range centers). Each division is a start, 48 shifts and the capture. A
// last step writes the output register once it is free. The output
// register holds one result, so beams keep flowing while it waits to be
// taken unless a second result is ready behind it.
// ---------------------------------------------------------------------------
module intensity_reflector_cluster_detect
    import irc_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data,
    input  logic                 beam_valid,
    output logic                 beam_stall,
    input  beam_t                beam,
    output logic                 result_valid,
    input  logic                 result_stall,
    output result_t              result
);

    cmd_t    cmd;
    status_t status;

    irc_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .beam_valid (beam_valid),
        .beam_stall (beam_stall),
        .status     (status),
        .cmd        (cmd)
    );

    irc_dp u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .beam         (beam),
        .cmd          (cmd),
        .status       (status),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

    a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |-> (!result_valid || !result_stall))
        else $error("result overwritten while stalled");

    a_one_beam: assert property (@(posedge clk) disable iff (!rst_n)
        (beam_valid && !beam_stall) |=> beam_stall)
        else $error("second beam taken during evaluation");

    a_result_src: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result_valid) |-> $past(cmd.emit))
        else $error("result raised without emit");

endmodule

FILE: rtl/core/irc_div.sv
// ---------------------------------------------------------------------------
// irc_div: restoring divider, one dividend bit per cycle
// Keeps the low Q_W quotient bits; divisor must be nonzero.
// ---------------------------------------------------------------------------
module irc_div
    import irc_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [DVD_W-1:0] dividend,
    input  logic [WS_W-1:0]  divisor,
    output logic             done,
    output logic [Q_W-1:0]   quotient
);

    logic [DVD_W-1:0]     dvd_reg;
    logic [WS_W-1:0]      rem_reg;
    logic [Q_W-1:0]       q_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic                 busy_reg;
    logic                 done_reg;
    logic [WS_W:0]        trial;
    logic                 fits;

    assign trial = {rem_reg, dvd_reg[DVD_W-1]};
    assign fits  = trial >= {1'b0, divisor};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= DIV_CNT_W'(DVD_W);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == DIV_CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            dvd_reg <= dividend;
            rem_reg <= '0;
            q_reg   <= '0;
        end
        else if (busy_reg)
        begin
            dvd_reg <= {dvd_reg[DVD_W-2:0], 1'b0};
            rem_reg <= fits ? WS_W'(trial - {1'b0, divisor}) : trial[WS_W-1:0];
            q_reg   <= {q_reg[Q_W-2:0], fits};
        end
    end

    assign done     = done_reg;
    assign quotient = q_reg;

endmodule

FILE: rtl/core/irc_dp.sv
// ---------------------------------------------------------------------------
// irc_dp: datapath of the reflector cluster detector
// Registers, beam counter, cluster accumulators, checks, divider, output reg.
// ---------------------------------------------------------------------------
module irc_dp
    import irc_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data,
    input  beam_t                beam,
    input  cmd_t                 cmd,
    output status_t              status,
    output logic                 result_valid,
    input  logic                 result_stall,
    output result_t              result
);

    logic [INT_W-1:0]         thr_reg;
    logic [CNT_W-1:0]         minp_reg;
    logic [RNG_W-1:0]         span_max_reg;
    logic [CFG_W-1:0]         wmin_reg;
    logic [CFG_W-1:0]         wmax_reg;
    logic signed [STEP_W-1:0] step_reg;
    logic [RNG_W-1:0]         floor_reg;
    logic [RNG_W-1:0]         ceil_reg;

    beam_t                    beam_reg;
    logic [CNT_W-1:0]         counter_reg;
    logic                     in_cluster_reg;
    logic [IDX_W-1:0]         start_reg;
    logic [CNT_W-1:0]         size_reg;
    logic [WS_W-1:0]          ws_reg;
    logic [IWS_W-1:0]         iws_reg;
    logic [RWS_W-1:0]         rws_reg;
    logic [RNG_W-1:0]         near_reg;
    logic [RNG_W-1:0]         far_reg;
    logic [INT_W-1:0]         peak_reg;
    logic                     add_reg;
    logic                     close_reg;
    logic [IDX_W+INT_W-1:0]   pidx_reg;
    logic [RNG_W+INT_W-1:0]   prng_reg;
    logic [WIDTH_W-1:0]       width_reg;
    logic [Q_W-1:0]           q8_reg;
    logic [RNG_W-1:0]         crng_reg;
    logic                     result_valid_reg;
    result_t                  result_reg;

    logic [IDX_W-1:0]         idx;
    logic                     in_window;
    logic                     bright;
    logic                     join_beam;
    logic                     rng_ok;
    logic                     close_now;
    logic [RNG_W-1:0]         base_near;
    logic [RNG_W-1:0]         base_far;
    logic [INT_W-1:0]         base_peak;
    logic [CNT_W-1:0]         base_size;
    logic [STEP_W-1:0]        step_mag;
    logic [RNG_W-1:0]         span;
    logic [IDX_W-1:0]         size_less;
    logic [DVD_W-1:0]         div_dividend;
    logic                     div_done;
    logic [Q_W-1:0]           div_q;
    logic [Q_W:0]             q8_round;
    logic                     out_free;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg      <= INT_W'(45);
            minp_reg     <= CNT_W'(5);
            span_max_reg <= RNG_W'(30);
            wmin_reg     <= CFG_W'(10000);
            wmax_reg     <= CFG_W'(120000);
            step_reg     <= STEP_W'(8727);
            floor_reg    <= RNG_W'(150);
            ceil_reg     <= RNG_W'(12000);
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_THRESHOLD:  thr_reg      <= cfg_data[INT_W-1:0];
                REG_MIN_POINTS: minp_reg     <= cfg_data[CNT_W-1:0];
                REG_MAX_SPAN:   span_max_reg <= cfg_data[RNG_W-1:0];
                REG_MIN_WIDTH:  wmin_reg     <= cfg_data;
                REG_MAX_WIDTH:  wmax_reg     <= cfg_data;
                REG_ANGLE_STEP: step_reg     <= signed'(cfg_data[STEP_W-1:0]);
                REG_RANGE_LO:   floor_reg    <= cfg_data[RNG_W-1:0];
                REG_RANGE_HI:   ceil_reg     <= cfg_data[RNG_W-1:0];
                default:        ;
            endcase
        end
    end

    // beam classification
    assign idx       = counter_reg[IDX_W-1:0];
    assign in_window = counter_reg < CNT_W'(BEAM_COUNT);
    assign bright    = beam_reg.beam_intensity >= thr_reg;
    assign join_beam = in_window && bright;
    assign rng_ok    = beam_reg.range_finite && (beam_reg.beam_range_mm >= floor_reg)
                       && (beam_reg.beam_range_mm <= ceil_reg);
    assign close_now = (in_window && !bright && in_cluster_reg)
                       || (beam_reg.last_beam && (in_cluster_reg || join_beam));

    // a new cluster starts from the empty values
    assign base_near = in_cluster_reg ? near_reg : '1;
    assign base_far  = in_cluster_reg ? far_reg : '0;
    assign base_peak = in_cluster_reg ? peak_reg : '0;
    assign base_size = in_cluster_reg ? size_reg : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            counter_reg    <= '0;
            in_cluster_reg <= 1'b0;
            add_reg        <= 1'b0;
            close_reg      <= 1'b0;
        end
        else if (cmd.eval)
        begin
            if (beam_reg.last_beam)
            begin
                counter_reg <= '0;
            end
            else if (in_window)
            begin
                counter_reg <= counter_reg + 1'b1;
            end
            in_cluster_reg <= close_now ? 1'b0 : (join_beam ? 1'b1 : in_cluster_reg);
            add_reg        <= join_beam && rng_ok;
            close_reg      <= close_now;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            beam_reg <= beam;
        end
        if (cmd.eval)
        begin
            pidx_reg <= idx * beam_reg.beam_intensity;
            prng_reg <= beam_reg.beam_range_mm * beam_reg.beam_intensity;
            if (join_beam)
            begin
                size_reg <= base_size + 1'b1;
                near_reg <= base_near;
                far_reg  <= base_far;
                peak_reg <= base_peak;
                if (!in_cluster_reg)
                begin
                    start_reg <= idx;
                    ws_reg    <= '0;
                    iws_reg   <= '0;
                    rws_reg   <= '0;
                end
                if (rng_ok)
                begin
                    if (beam_reg.beam_range_mm < base_near)
                        near_reg <= beam_reg.beam_range_mm;
                    if (beam_reg.beam_range_mm > base_far)
                        far_reg <= beam_reg.beam_range_mm;
                    if (beam_reg.beam_intensity > base_peak)
                        peak_reg <= beam_reg.beam_intensity;
                end
            end
        end
        if (cmd.accum && add_reg)
        begin
            ws_reg  <= ws_reg + WS_W'(beam_reg.beam_intensity);
            iws_reg <= iws_reg + IWS_W'(pidx_reg);
            rws_reg <= rws_reg + RWS_W'(prng_reg);
        end
        if (cmd.width)
        begin
            width_reg <= size_less * step_mag;
        end
        if (cmd.cap_center)
        begin
            q8_reg <= div_q;
        end
        if (cmd.cap_range)
        begin
            crng_reg <= div_q[RNG_W-1:0];
        end
    end

    // acceptance checks
    assign step_mag  = step_reg[STEP_W-1] ? STEP_W'(-step_reg) : STEP_W'(step_reg);
    assign size_less = IDX_W'(size_reg - 1'b1);
    assign span      = (far_reg >= near_reg) ? RNG_W'(far_reg - near_reg) : '0;

    assign status.close    = close_reg;
    assign status.accept   = (size_reg >= minp_reg) && (ws_reg != '0)
                             && (span <= span_max_reg)
                             && (width_reg >= WIDTH_W'(wmin_reg))
                             && (width_reg <= WIDTH_W'(wmax_reg));
    assign status.div_done = div_done;
    assign status.out_free = out_free;

    // index sum is scaled by 256 so one division gives the q8 center
    assign div_dividend = cmd.div_sel ? DVD_W'(rws_reg) : {iws_reg, {FRAC_W{1'b0}}};

    irc_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (div_dividend),
        .divisor  (ws_reg),
        .done     (div_done),
        .quotient (div_q)
    );

    // rounding half up equals adding one half in q8
    assign q8_round = {1'b0, q8_reg} + (Q_W+1)'(1 << (FRAC_W - 1));
    assign out_free = !result_valid_reg || !result_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else if (cmd.emit)
        begin
            result_valid_reg <= 1'b1;
        end
        else if (!result_stall)
        begin
            result_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            result_reg.center_index_q8 <= q8_reg;
            result_reg.peak_index      <= q8_round[FRAC_W +: IDX_W];
            result_reg.start_index     <= start_reg;
            result_reg.end_index       <= start_reg + size_less;
            result_reg.peak_intensity  <= peak_reg;
            result_reg.center_range_mm <= crng_reg;
        end
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

endmodule

FILE: rtl/core/irc_ctrl.sv
// ---------------------------------------------------------------------------
// irc_ctrl: sequencer of the reflector cluster detector
// Steps one beam through eval/accumulate, judges on close, divides if accepted.
// ---------------------------------------------------------------------------
module irc_ctrl
    import irc_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    beam_valid,
    output logic    beam_stall,
    input  status_t status,
    output cmd_t    cmd
);

    typedef enum logic [9:0] {
        S_IDLE  = 10'b0000000001,
        S_EVAL  = 10'b0000000010,
        S_ACC   = 10'b0000000100,
        S_WIDTH = 10'b0000001000,
        S_JUDGE = 10'b0000010000,
        S_DIV1  = 10'b0000100000,
        S_WAIT1 = 10'b0001000000,
        S_DIV2  = 10'b0010000000,
        S_WAIT2 = 10'b0100000000,
        S_WRITE = 10'b1000000000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        beam_stall = 1'b1;
        unique case (state_reg)
            S_IDLE:
            begin
                beam_stall = 1'b0;
                if (beam_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_EVAL;
                end
            end
            S_EVAL:
            begin
                cmd.eval   = 1'b1;
                state_next = S_ACC;
            end
            S_ACC:
            begin
                cmd.accum  = 1'b1;
                state_next = status.close ? S_WIDTH : S_IDLE;
            end
            S_WIDTH:
            begin
                cmd.width  = 1'b1;
                state_next = S_JUDGE;
            end
            S_JUDGE:
            begin
                state_next = status.accept ? S_DIV1 : S_IDLE;
            end
            S_DIV1:
            begin
                cmd.div_start = 1'b1;
                state_next    = S_WAIT1;
            end
            S_WAIT1:
            begin
                if (status.div_done)
                begin
                    cmd.cap_center = 1'b1;
                    state_next     = S_DIV2;
                end
            end
            S_DIV2:
            begin
                cmd.div_start = 1'b1;
                cmd.div_sel   = 1'b1;
                state_next    = S_WAIT2;
            end
            S_WAIT2:
            begin
                cmd.div_sel = 1'b1;
                if (status.div_done)
                begin
                    cmd.cap_range = 1'b1;
                    state_next    = S_WRITE;
                end
            end
            S_WRITE:
            begin
                // hold until the output register can take the result
                if (status.out_free)
                begin
                    cmd.emit   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

FILE: tb/tb.sv
// ---------------------------------------------------------------------------
// tb: regression for the lidar reflector cluster detector
// Drives beams through the valid/stall handshake with random gaps, programs
// several register settings between phases, and checks every reported
// cluster against a cycle-free cluster predictor kept in the bench.
// ---------------------------------------------------------------------------
module tb
    import irc_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int DRAIN_CYCLES   = 200;

    typedef struct packed {
        beam_t   b;
        logic    typed;
        result_t r;
    } beam_row_t;

    // Opening rows run at the reset register values.
    localparam beam_row_t DIRECTED [22] = '{
        '{'{16'd100, 16'd1000, 1'b1, 1'b0}, 1'b0, '0},
        '{'{16'd100, 16'd1000, 1'b1, 1'b0}, 1'b0, '0},
        '{'{16'd100, 16'd1000, 1'b1, 1'b0}, 1'b0, '0},
        '{'{16'd100, 16'd1000, 1'b1, 1'b0}, 1'b0, '0},
        '{'{16'd100, 16'd1000, 1'b1, 1'b0}, 1'b0, '0},
        '{'{16'd0, 16'd1000, 1'b1, 1'b0}, 1'b1,
          '{20'd512, 12'd2, 12'd0, 12'd4, 16'd100, 16'd1000}},
        '{'{16'hFFFF, 16'hFFFF, 1'b1, 1'b0}, 1'b0, '0},
        '{'{16'hFFFF, 16'd0, 1'b1, 1'b0}, 1'b0, '0},
        '{'{16'd300, 16'd150, 1'b1, 1'b0}, 1'b0, '0},
        '{'{16'd300, 16'd12000, 1'b1, 1'b0}, 1'b0, '0},
        '{'{16'd45, 16'd160, 1'b0, 1'b0}, 1'b0, '0},
        '{'{16'd44, 16'd500, 1'b1, 1'b0}, 1'b0, '0},
        '{'{16'd44, 16'd500, 1'b1, 1'b1}, 1'b0, '0},
        '{'{16'd200, 16'd5000, 1'b1, 1'b0}, 1'b0, '0},
        '{'{16'd210, 16'd5001, 1'b1, 1'b0}, 1'b0, '0},
        '{'{16'd220, 16'd5002, 1'b1, 1'b0}, 1'b0, '0},
        '{'{16'd230, 16'd5003, 1'b1, 1'b0}, 1'b0, '0},
        '{'{16'd240, 16'd5004, 1'b1, 1'b0}, 1'b0, '0},
        '{'{16'd250, 16'd5005, 1'b1, 1'b0}, 1'b0, '0},
        '{'{16'd260, 16'd5006, 1'b1, 1'b1}, 1'b0, '0},
        '{'{16'hFFFF, 16'd5010, 1'b1, 1'b0}, 1'b0, '0},
        '{'{16'd0, 16'd5010, 1'b1, 1'b1}, 1'b0, '0}
    };

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0]     cfg_data;
    logic                 beam_valid;
    logic                 beam_stall;
    beam_t                beam;
    logic                 result_valid;
    logic                 result_stall;
    result_t              result;

    intensity_reflector_cluster_detect u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .beam_valid   (beam_valid),
        .beam_stall   (beam_stall),
        .beam         (beam),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

    // register shadow
    longint unsigned thr_reg   = 45;
    longint unsigned minp_reg  = 5;
    longint unsigned span_reg  = 30;
    longint unsigned minw_reg  = 10000;
    longint unsigned maxw_reg  = 120000;
    longint          step_reg  = 8727;
    longint unsigned floor_reg = 150;
    longint unsigned ceil_reg  = 12000;

    // cluster tracking state
    longint unsigned scan_idx  = 0;
    bit              clus_open = 0;
    longint unsigned clus_first = 0;
    longint unsigned clus_len  = 0;
    longint unsigned wsum      = 0;
    longint unsigned iwsum     = 0;
    longint unsigned rwsum     = 0;
    longint unsigned near_r    = 16'hFFFF;
    longint unsigned far_r     = 0;
    longint unsigned top_i     = 0;

    result_t pending_clusters [$];
    int      errors    = 0;
    bit      quiet     = 0;
    int      long_hold = 0;

    function automatic bit close_cluster(output result_t r);
        longint unsigned span, end_pos, mag, width, q, rem, frac, pk;
        r = '0;
        clus_open = 0;
        if (clus_len < minp_reg || wsum == 0)
            return 0;
        span = (far_r >= near_r) ? far_r - near_r : 0;
        if (span > span_reg)
            return 0;
        end_pos = clus_first + clus_len - 1;
        mag = (step_reg < 0) ? -step_reg : step_reg;
        width = (end_pos - clus_first) * mag;
        if (width < minw_reg || width > maxw_reg)
            return 0;
        q    = iwsum / wsum;
        rem  = iwsum % wsum;
        frac = (rem << 8) / wsum;
        pk   = (2 * rem >= wsum) ? q + 1 : q;
        r.center_index_q8 = Q_W'((q << 8) | frac);
        r.peak_index      = IDX_W'(pk);
        r.start_index     = IDX_W'(clus_first);
        r.end_index       = IDX_W'(end_pos);
        r.peak_intensity  = INT_W'(top_i);
        r.center_range_mm = RNG_W'(rwsum / wsum);
        return 1;
    endfunction

    function automatic bit track_beam(input beam_t b, output result_t r);
        longint unsigned inten, rng;
        bit hit;
        inten = b.beam_intensity;
        rng   = b.beam_range_mm;
        hit   = 0;
        r     = '0;
        if (scan_idx < BEAM_COUNT) begin
            if (inten >= thr_reg) begin
                if (!clus_open) begin
                    clus_open  = 1;
                    clus_first = scan_idx;
                    clus_len   = 0;
                    wsum = 0;
                    iwsum = 0;
                    rwsum = 0;
                    near_r = 16'hFFFF;
                    far_r = 0;
                    top_i = 0;
                end
                clus_len++;
                if (b.range_finite && rng >= floor_reg && rng <= ceil_reg) begin
                    wsum  += inten;
                    iwsum += scan_idx * inten;
                    rwsum += rng * inten;
                    if (rng < near_r) near_r = rng;
                    if (rng > far_r) far_r = rng;
                    if (inten > top_i) top_i = inten;
                end
            end else if (clus_open) begin
                hit = close_cluster(r);
            end
            scan_idx++;
        end
        if (b.last_beam) begin
            if (clus_open)
                hit = close_cluster(r);
            scan_idx = 0;
        end
        return hit;
    endfunction

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input longint unsigned v);
        logic [STEP_W-1:0] s;
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= CFG_W'(v);
        case (idx)
            REG_THRESHOLD:  thr_reg   = v & 16'hFFFF;
            REG_MIN_POINTS: minp_reg  = v & 13'h1FFF;
            REG_MAX_SPAN:   span_reg  = v & 16'hFFFF;
            REG_MIN_WIDTH:  minw_reg  = v & 23'h7FFFFF;
            REG_MAX_WIDTH:  maxw_reg  = v & 23'h7FFFFF;
            REG_ANGLE_STEP: begin
                s = STEP_W'(v);
                step_reg = longint'($signed(s));
            end
            REG_RANGE_LO:   floor_reg = v & 16'hFFFF;
            REG_RANGE_HI:   ceil_reg  = v & 16'hFFFF;
            default: ;
        endcase
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    // Called at a falling edge; returns at the falling edge after the transfer.
    task automatic send(input beam_t b, input bit typed, input result_t typed_r);
        int      gap;
        result_t r;
        gap = quiet ? 0 : $urandom_range(0, 11);
        if (gap > 0) begin
            beam_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        beam       <= b;
        beam_valid <= 1'b1;
        do @(posedge clk); while (beam_stall);
        if (track_beam(b, r))
            pending_clusters = {pending_clusters, (typed ? typed_r : r)};
        @(negedge clk);
    endtask

    task automatic settle;
        @(negedge clk);
        beam_valid <= 1'b0;
        wait (pending_clusters.size() == 0);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic check_field(input string name, input longint unsigned e,
                               input longint unsigned a);
        if (e != a) begin
            $error("%s: expected %0d, got %0d", name, e, a);
            errors++;
        end
    endtask

    initial begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // result side: hold off for a drawn number of cycles, then take one result
    initial begin
        int n;
        result_stall = 1'b1;
        wait (rst_n);
        forever begin
            @(negedge clk);
            n = (long_hold > 0) ? long_hold : (quiet ? 0 : $urandom_range(0, 11));
            long_hold = 0;
            if (n > 0) begin
                result_stall <= 1'b1;
                repeat (n) @(negedge clk);
            end
            result_stall <= 1'b0;
            do @(posedge clk); while (!result_valid);
        end
    end

    always @(posedge clk) begin
        result_t e;
        if (rst_n && result_valid && !result_stall) begin
            if (pending_clusters.size() == 0) begin
                $error("unexpected cluster result %h", result);
                errors++;
            end else begin
                e = pending_clusters.pop_front();
                check_field("center_index_q8", e.center_index_q8, result.center_index_q8);
                check_field("peak_index", e.peak_index, result.peak_index);
                check_field("start_index", e.start_index, result.start_index);
                check_field("end_index", e.end_index, result.end_index);
                check_field("peak_intensity", e.peak_intensity, result.peak_intensity);
                check_field("center_range_mm", e.center_range_mm, result.center_range_mm);
            end
        end
    end

    initial begin
        int idle_cycles;
        idle_cycles = 0;
        forever begin
            @(posedge clk);
            if ((beam_valid && !beam_stall) || (result_valid && !result_stall) || cfg_we)
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("intensity_reflector_cluster_detect regression: fail");
                $finish;
            end
        end
    end

    initial begin
        beam_t           b;
        int              quota, run_left, scan_left;
        longint unsigned base, jit;
        bit              noise;
        int              kinds [9];

        kinds      = '{0, 0, 1, 0, 2, 3, 0, 0, 0};
        rst_n      = 1'b0;
        cfg_we     = 1'b0;
        cfg_index  = '0;
        cfg_data   = '0;
        beam_valid = 1'b0;
        beam       = '0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (DIRECTED[i])
            send(DIRECTED[i].b, DIRECTED[i].typed, DIRECTED[i].r);

        foreach (kinds[p]) begin
            settle();
            case (kinds[p])
                1: begin
                    // everything bright, widest limits, negative step
                    write_reg(REG_THRESHOLD, 0);
                    write_reg(REG_MIN_POINTS, 0);
                    write_reg(REG_MAX_SPAN, 65535);
                    write_reg(REG_MIN_WIDTH, 0);
                    write_reg(REG_MAX_WIDTH, 6283185);
                    write_reg(REG_ANGLE_STEP, -100000);
                    write_reg(REG_RANGE_LO, 0);
                    write_reg(REG_RANGE_HI, 65535);
                end
                2: begin
                    // nothing can pass: floor above ceiling, min width above max
                    write_reg(REG_THRESHOLD, 65535);
                    write_reg(REG_MIN_POINTS, 4096);
                    write_reg(REG_MAX_SPAN, 0);
                    write_reg(REG_MIN_WIDTH, 6283185);
                    write_reg(REG_MAX_WIDTH, 0);
                    write_reg(REG_ANGLE_STEP, 100000);
                    write_reg(REG_RANGE_LO, 65535);
                    write_reg(REG_RANGE_HI, 0);
                end
                default: begin
                    write_reg(REG_THRESHOLD, $urandom_range(1, 4000));
                    write_reg(REG_MIN_POINTS, $urandom_range(1, 6));
                    write_reg(REG_MAX_SPAN, $urandom_range(0, 3000));
                    if (kinds[p] == 3) begin
                        write_reg(REG_MIN_WIDTH, $urandom_range(200000, 300000));
                        write_reg(REG_MAX_WIDTH, $urandom_range(0, 199999));
                    end else begin
                        write_reg(REG_MIN_WIDTH, $urandom_range(0, 20000));
                        write_reg(REG_MAX_WIDTH, $urandom_range(60000, 400000));
                    end
                    write_reg(REG_ANGLE_STEP, $urandom_range(0, 1) ?
                              -longint'($urandom_range(0, 30000)) :
                              longint'($urandom_range(0, 30000)));
                    write_reg(REG_RANGE_LO, $urandom_range(0, 2000));
                    write_reg(REG_RANGE_HI, $urandom_range(8000, 65535));
                end
            endcase
            @(negedge clk);

            quiet     = ($urandom_range(0, 3) == 0);
            quota     = (kinds[p] == 2) ? 60 : 145;
            run_left  = 0;
            scan_left = $urandom_range(5, 80);
            for (int k = 0; k < quota; k++) begin
                if (p == 3 && k == 20)
                    long_hold = 1500;
                if (p == 3 && k == 90) begin
                    @(negedge clk);
                    beam_valid <= 1'b0;
                    wait (pending_clusters.size() == 0);
                    @(negedge clk);
                end
                if (run_left == 0 && $urandom_range(0, 2) == 0) begin
                    run_left = $urandom_range(1, 14);
                    base = (floor_reg <= ceil_reg) ? $urandom_range(floor_reg, ceil_reg)
                                                   : $urandom_range(0, 65535);
                    jit = (span_reg > 4000) ? 4000 : span_reg + 20;
                end
                noise = ($urandom_range(0, 9) == 0);
                if (noise) begin
                    b = $bits(beam_t)'({$urandom, $urandom});
                end else begin
                    if (run_left > 0)
                        b.beam_intensity = INT_W'($urandom_range(thr_reg, 65535));
                    else
                        b.beam_intensity = (thr_reg == 0) ? '0
                                           : INT_W'($urandom_range(0, thr_reg - 1));
                    b.beam_range_mm = ($urandom_range(0, 15) == 0)
                                      ? RNG_W'($urandom_range(0, 65535))
                                      : RNG_W'(base + $urandom_range(0, jit));
                    b.range_finite = ($urandom_range(0, 15) != 0);
                    b.last_beam    = 1'b0;
                end
                if (run_left > 0)
                    run_left--;
                scan_left--;
                if (scan_left == 0) begin
                    b.last_beam = 1'b1;
                    scan_left = $urandom_range(5, 80);
                end
                send(b, 1'b0, '0);
            end
            // close whatever is open so the next setting starts a fresh scan
            b = '0;
            b.last_beam = 1'b1;
            send(b, 1'b0, '0);
        end

        @(negedge clk);
        beam_valid <= 1'b0;
        wait (pending_clusters.size() == 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (errors == 0)
            $display("intensity_reflector_cluster_detect regression: pass");
        else
            $display("intensity_reflector_cluster_detect regression: fail");
        $finish;
    end

endmodule
